// ===== rtl/ilx_pkg.sv =====
// Shared types, codes and widths for the indexed list engine.
package ilx_pkg;

  // Field widths of the command and result beats.
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 9;

  // Default number of entries the list can hold.
  localparam int CAPACITY_DEF = 256;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_READ = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HEAD = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TAIL = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_AT   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [INDEX_W-1:0] index;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [LEN_W-1:0]          length;
  } out_item_t;

  // What a decoded command does to the store.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_INS,
    OP_DEL
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic decide;
    logic shift;
    logic capture;
    logic commit;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  dec_op;
    logic dec_shift;
    logic shift_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/indexed_list_engine.sv =====
// Top level of the indexed list engine: ordered list of signed words with positional edits.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready  | in_data  (action, index, value)
//   out_    | output    | out_valid / out_ready| out_data (read_value, status, length)
//
// One command is worked on at a time. A rejected command goes from decode to the result,
// a read waits for the store data, and an insert or delete commits after its entries move.
// The moves go through the single write port of the entry store, one entry a cycle.
// Reset clears the length and the control state; the entries hold no reset value.
// A finished result waits in the output register while the next command is taken and
// worked on; that command's result is loaded, and the input opened again, only once
// the register has been handed over or is free.
module indexed_list_engine #(
  parameter int CAPACITY = ilx_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ilx_pkg::out_item_t out_data
);

  ilx_pkg::ctl_cmd_t cmd;
  ilx_pkg::dp_stat_t stat;

  // Sequencing.
  ilx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, decode and result register.
  ilx_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/ilx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ilx_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ilx_ctrl.sv =====
// Controller state machine sequencing decode, shifting and result hand-off.
module ilx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilx_pkg::dp_stat_t stat,
  output ilx_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_WAIT,
    S_SHIFT,
    S_DRAIN,
    S_COMMIT,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.dec_op)
          ilx_pkg::OP_NONE: state_nxt = S_RESP;
          ilx_pkg::OP_READ: state_nxt = S_RD_WAIT;
          default:          state_nxt = stat.dec_shift ? S_SHIFT : S_COMMIT;
        endcase
      end
      S_RD_WAIT: state_nxt = S_RESP;
      S_SHIFT: begin
        if (stat.shift_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_RESP;
      S_RESP: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands decoded from the current state.
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd.take     = (state_r == S_IDLE) && in_valid;
    cmd.decide   = (state_r == S_DECIDE);
    cmd.shift    = (state_r == S_SHIFT);
    cmd.capture  = (state_r == S_RD_WAIT);
    cmd.commit   = (state_r == S_COMMIT);
    cmd.load_out = (state_r == S_RESP) && stat.out_free;
  end

endmodule

// ===== rtl/ilx_dp.sv =====
// Datapath: command decode, entry store, shift pipeline and result register.
module ilx_dp #(
  parameter int CAPACITY = ilx_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ilx_pkg::in_item_t  in_data,
  input  ilx_pkg::ctl_cmd_t  cmd,
  output ilx_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output ilx_pkg::out_item_t out_data
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = ((CNT_W > ilx_pkg::INDEX_W - 1) ? CNT_W : ilx_pkg::INDEX_W - 1) + 1;

  ilx_pkg::in_item_t          cmd_r;
  ilx_pkg::op_t               op_r;
  logic [CNT_W-1:0]           count_r;
  logic [ADDR_W-1:0]          pos_r;
  logic [ADDR_W-1:0]          ptr_r;
  logic                       pend_r;
  logic [ADDR_W-1:0]          paddr_r;
  logic [ilx_pkg::STATUS_W-1:0] res_status_r;
  logic [ilx_pkg::VALUE_W-1:0]  res_value_r;
  ilx_pkg::out_item_t         out_r;
  logic                       out_valid_r;

  ilx_pkg::op_t               dec_op;
  logic [ADDR_W-1:0]          dec_pos;
  logic                       dec_shift;
  logic [ilx_pkg::STATUS_W-1:0] dec_status;
  logic [ilx_pkg::VALUE_W-1:0]  dec_value;

  logic                       idx_neg;
  logic [CMP_W-1:0]           idx_ext;
  logic [CMP_W-1:0]           cnt_ext;
  logic                       rd_ok;
  logic                       at_ok;
  logic                       full;
  logic [CNT_W-1:0]           cnt_m1;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [ilx_pkg::VALUE_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [ilx_pkg::VALUE_W-1:0] ram_rdata;

  // Position checks against the current length.
  assign idx_neg = cmd_r.index[ilx_pkg::INDEX_W-1];
  assign idx_ext = CMP_W'(cmd_r.index[ilx_pkg::INDEX_W-2:0]);
  assign cnt_ext = CMP_W'(count_r);
  assign rd_ok   = !idx_neg && (idx_ext < cnt_ext);
  assign at_ok   = idx_neg || (idx_ext <= cnt_ext);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign cnt_m1  = count_r - CNT_W'(1);

  // Decode the held command into an operation, a position and a status.
  always_comb begin
    dec_op     = ilx_pkg::OP_NONE;
    dec_pos    = '0;
    dec_status = ilx_pkg::ST_OK;
    dec_value  = '0;
    unique case (cmd_r.action)
      ilx_pkg::ACT_READ: begin
        if (rd_ok) begin
          dec_op  = ilx_pkg::OP_READ;
          dec_pos = idx_ext[ADDR_W-1:0];
        end else begin
          dec_status = ilx_pkg::ST_RANGE;
          dec_value  = '1;
        end
      end
      ilx_pkg::ACT_HEAD: begin
        if (full) begin
          dec_status = ilx_pkg::ST_FULL;
        end else begin
          dec_op = ilx_pkg::OP_INS;
        end
      end
      ilx_pkg::ACT_TAIL: begin
        if (full) begin
          dec_status = ilx_pkg::ST_FULL;
        end else begin
          dec_op  = ilx_pkg::OP_INS;
          dec_pos = count_r[ADDR_W-1:0];
        end
      end
      ilx_pkg::ACT_AT: begin
        // The range check comes before the full check; negative clamps to the head.
        if (!at_ok) begin
          dec_status = ilx_pkg::ST_RANGE;
        end else if (full) begin
          dec_status = ilx_pkg::ST_FULL;
        end else begin
          dec_op  = ilx_pkg::OP_INS;
          dec_pos = idx_neg ? '0 : idx_ext[ADDR_W-1:0];
        end
      end
      ilx_pkg::ACT_DEL: begin
        if (rd_ok) begin
          dec_op  = ilx_pkg::OP_DEL;
          dec_pos = idx_ext[ADDR_W-1:0];
        end else begin
          dec_status = ilx_pkg::ST_RANGE;
        end
      end
      default: begin
        dec_status = ilx_pkg::ST_RANGE;
      end
    endcase
  end

  // Entries must move when the insert lands before the tail, or the delete is not the last.
  always_comb begin
    if (dec_op == ilx_pkg::OP_INS) begin
      dec_shift = (CNT_W'(dec_pos) < count_r);
    end else begin
      dec_shift = ((CNT_W'(dec_pos) + CNT_W'(1)) < count_r);
    end
  end

  assign stat.dec_op     = dec_op;
  assign stat.dec_shift  = dec_shift;
  assign stat.shift_last = (op_r == ilx_pkg::OP_INS) ? (ptr_r == pos_r)
                                                      : (ptr_r == cnt_m1[ADDR_W-1:0]);
  assign stat.out_free   = !out_valid_r || out_ready;

  // Store ports: the shift reads one entry a cycle and writes it back one place over.
  assign ram_re    = cmd.shift || (cmd.decide && (dec_op == ilx_pkg::OP_READ));
  assign ram_raddr = cmd.shift ? ptr_r : dec_pos;
  assign ram_we    = pend_r || (cmd.commit && (op_r == ilx_pkg::OP_INS));
  always_comb begin
    if (pend_r) begin
      ram_waddr = (op_r == ilx_pkg::OP_INS) ? (paddr_r + ADDR_W'(1)) : (paddr_r - ADDR_W'(1));
      ram_wdata = ram_rdata;
    end else begin
      ram_waddr = pos_r;
      ram_wdata = cmd_r.value;
    end
  end

  ilx_ram #(
    .WIDTH  (ilx_pkg::VALUE_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Command, decision and shift pointer registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_r <= in_data;
    end
    if (cmd.decide) begin
      op_r         <= dec_op;
      pos_r        <= dec_pos;
      res_status_r <= dec_status;
      res_value_r  <= dec_value;
      ptr_r        <= (dec_op == ilx_pkg::OP_INS) ? cnt_m1[ADDR_W-1:0]
                                                  : (dec_pos + ADDR_W'(1));
    end else if (cmd.shift) begin
      ptr_r <= (op_r == ilx_pkg::OP_INS) ? (ptr_r - ADDR_W'(1)) : (ptr_r + ADDR_W'(1));
    end
    if (cmd.capture) begin
      res_value_r <= ram_rdata;
    end
    paddr_r <= ptr_r;
    if (cmd.load_out) begin
      out_r.read_value <= res_value_r;
      out_r.status     <= res_status_r;
      out_r.length     <= ilx_pkg::LEN_W'(count_r);
    end
  end

  // Control state: length, pending write and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= cmd.shift;
      if (cmd.commit) begin
        count_r <= (op_r == ilx_pkg::OP_INS) ? (count_r + CNT_W'(1)) : cnt_m1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // The length never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  // The length changes only when a command commits.
  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(count_r))
    else $error("list length changed outside commit");

  // A committed insert grows the list by exactly one.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r == ilx_pkg::OP_INS)) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  // The last shifted entry is written before the new value, never in the same cycle.
  a_wr_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && cmd.commit && (op_r == ilx_pkg::OP_INS)))
    else $error("shift write collides with insert write");
`endif

endmodule
